// ----- hw/rtl/fbc_pkg.sv -----
// fbc_pkg: shared types and constants for the four-bit processor step block
// no dependencies
`timescale 1ns / 1ps
package fbc_pkg;
  localparam int ROM_DEPTH = 4096;
  localparam int RAM_BANKS = 8;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int DRAM_DEPTH = RAM_BANKS * 256;
  localparam int SRAM_DEPTH = RAM_BANKS * 64;
  localparam int DRAM_AW = $clog2(DRAM_DEPTH);
  localparam int SRAM_AW = $clog2(SRAM_DEPTH);

  localparam logic [1:0] FUNC_EXEC = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_PORT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH1, ST_DEC1, ST_FETCH2, ST_DEC2,
    ST_FINRD, ST_FINWR, ST_RAMRD, ST_RAMEX, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_PASS, ALU_INC, ALU_DEC
  } alu_op_t;

  function automatic logic [2:0] bank_code(input logic [2:0] a);
    unique case (a)
      3'd3: bank_code = 3'd4;
      3'd4: bank_code = 3'd3;
      default: bank_code = a;
    endcase
  endfunction

  function automatic logic [3:0] kbp(input logic [3:0] a);
    unique case (a)
      4'd0, 4'd1, 4'd2: kbp = a;
      4'd4: kbp = 4'd3;
      4'd8: kbp = 4'd4;
      default: kbp = 4'd15;
    endcase
  endfunction
endpackage

// ----- hw/rtl/four_bit_cpu_instruction_step.sv -----
// four_bit_cpu_instruction_step: sequenced 4-bit processor core, one instruction per request
// depends on fbc_pkg
//
// in channel: in_tdata holds address[11:0], value[19:12], test_pin[20] (24 bits),
//   in_tuser holds func. func 0 executes one instruction, 1 loads a ROM byte,
//   2 sets a ROM input port, 3 only reports state.
// out channel: one result per request, tdata fields listed at the port.
// sequence: load, port and no-op requests pass through ST_DONE to the output register.
//   an execute passes ST_FETCH1 and ST_DEC1, then ST_FETCH2 and ST_DEC2 for a second
//   byte, ST_FINRD and ST_FINWR for a FIN fetch, or ST_RAMRD and ST_RAMEX for a data/status
//   RAM read; the single ROM port and the single RAM ports set this order. one shared
//   4-bit adder does the accumulator and index arithmetic, apart from the DAA +6.
// reset: a clearing pass walks every data RAM entry after reset, one entry of
//   data and status RAM each cycle; no request is taken meanwhile.
// stall: a result waits in the output register while out_tready is low; the
//   next request is taken once it has left.
`timescale 1ns / 1ps
module four_bit_cpu_instruction_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[11:0], value[19:12], test_pin[20]
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // pc_out[11:0], acc_out[15:12], carry_out[16],
                                  // halted[17], cycles_used[19:18], port_write[20],
                                  // port_index[25:21], port_value[29:26]
);
  fbc_pkg::state_t st_r, st_nxt;

  logic [7:0] rom [fbc_pkg::ROM_DEPTH];
  logic [3:0] dram [fbc_pkg::DRAM_DEPTH];
  logic [3:0] sram [fbc_pkg::SRAM_DEPTH];

  logic [3:0]  ports_r [16];
  logic [3:0]  idx_r [16];
  logic [11:0] stk_r [4];
  logic [3:0]  acc_r;
  logic        cy_r, halt_r;
  logic [2:0]  bank_r;
  logic [3:0]  srch_r, srcl_r;
  logic [1:0]  func_r;
  logic [11:0] addr_r;
  logic [7:0]  val_r, op_r, b2_r;
  logic        test_r;
  logic [7:0]  rom_q;
  logic [3:0]  dram_q, sram_q;
  logic [fbc_pkg::DRAM_AW:0] clr_r;
  logic [1:0]  cyc_r;
  logic        pw_r;
  logic [4:0]  pidx_r;
  logic [3:0]  pval_r;
  logic        ovalid_r;

  // rom port control
  logic [11:0] rom_a;
  logic        rom_we;
  logic [11:0] fin_a;
  assign fin_a = {stk_r[0][11:8], idx_r[0], idx_r[1]};

  logic [3:0] hi, lo;
  assign hi = op_r[7:4];
  assign lo = op_r[3:0];
  logic bank_ok;
  assign bank_ok = 32'(bank_r) < fbc_pkg::RAM_BANKS;
  logic [fbc_pkg::DRAM_AW-1:0] da;
  logic [fbc_pkg::SRAM_AW-1:0] sa;
  assign da = fbc_pkg::DRAM_AW'({bank_r, srch_r, srcl_r});
  assign sa = fbc_pkg::SRAM_AW'({bank_r, srch_r, lo[1:0]});

  // shared alu
  fbc_pkg::alu_op_t aop;
  logic [3:0] aa, ab;
  logic       acin;
  logic [4:0] asum;
  always_comb begin
    aa = acc_r; ab = 4'd0; acin = cy_r; aop = fbc_pkg::ALU_PASS;
    if (st_r == fbc_pkg::ST_RAMEX) begin
      ab = bank_ok ? dram_q : 4'd0;
      aop = (lo == 4'h8) ? fbc_pkg::ALU_SUB : fbc_pkg::ALU_ADD;
    end else begin
      ab = idx_r[lo];
      unique case (hi)
        4'h6, 4'h7: begin aa = idx_r[lo]; aop = fbc_pkg::ALU_INC; end
        4'h8: aop = fbc_pkg::ALU_ADD;
        4'h9: aop = fbc_pkg::ALU_SUB;
        4'hf: aop = (lo == 4'h8) ? fbc_pkg::ALU_DEC : fbc_pkg::ALU_INC;
        default: aop = fbc_pkg::ALU_PASS;
      endcase
    end
    unique case (aop)
      fbc_pkg::ALU_ADD: asum = {1'b0, aa} + {1'b0, ab} + {4'd0, acin};
      fbc_pkg::ALU_SUB: asum = {1'b0, aa} + {1'b0, ~ab} + {4'd0, acin};
      fbc_pkg::ALU_INC: asum = {1'b0, aa} + 5'd1;
      fbc_pkg::ALU_DEC: asum = {1'b0, aa} + 5'h0f;
      default: asum = {1'b0, aa};
    endcase
  end

  logic two_byte;
  assign two_byte = (hi == 4'h1) || (hi == 4'h2 && !lo[0]) || hi == 4'h4 ||
                    hi == 4'h5 || hi == 4'h7;
  logic ram_rd;
  assign ram_rd = hi == 4'he && (lo == 4'h8 || lo == 4'h9 || lo == 4'hb || lo >= 4'hc);
  logic fin_op;
  assign fin_op = hi == 4'h3 && !lo[0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      fbc_pkg::ST_CLEAR:
        if (clr_r == (fbc_pkg::DRAM_AW+1)'(fbc_pkg::DRAM_DEPTH - 1)) st_nxt = fbc_pkg::ST_IDLE;
      fbc_pkg::ST_IDLE:
        if (in_tvalid && !ovalid_r) begin
          if (in_tuser == fbc_pkg::FUNC_EXEC && !halt_r) st_nxt = fbc_pkg::ST_FETCH1;
          else st_nxt = fbc_pkg::ST_DONE;
        end
      fbc_pkg::ST_FETCH1: st_nxt = fbc_pkg::ST_DEC1;
      fbc_pkg::ST_DEC1:
        if (two_byte) st_nxt = fbc_pkg::ST_FETCH2;
        else if (fin_op) st_nxt = fbc_pkg::ST_FINRD;
        else if (ram_rd) st_nxt = fbc_pkg::ST_RAMRD;
        else st_nxt = fbc_pkg::ST_IDLE;
      fbc_pkg::ST_FETCH2: st_nxt = fbc_pkg::ST_DEC2;
      fbc_pkg::ST_DEC2: st_nxt = fbc_pkg::ST_IDLE;
      fbc_pkg::ST_FINRD: st_nxt = fbc_pkg::ST_FINWR;
      fbc_pkg::ST_FINWR: st_nxt = fbc_pkg::ST_IDLE;
      fbc_pkg::ST_RAMRD: st_nxt = fbc_pkg::ST_RAMEX;
      fbc_pkg::ST_RAMEX: st_nxt = fbc_pkg::ST_IDLE;
      fbc_pkg::ST_DONE: st_nxt = fbc_pkg::ST_IDLE;
      default: st_nxt = fbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == fbc_pkg::ST_IDLE) && !ovalid_r;
    rom_we = st_r == fbc_pkg::ST_DONE && func_r == fbc_pkg::FUNC_LOAD &&
             32'(addr_r) < fbc_pkg::ROM_DEPTH;
    unique case (st_r)
      fbc_pkg::ST_FINRD: rom_a = fin_a;
      fbc_pkg::ST_DONE: rom_a = addr_r;
      default: rom_a = stk_r[0];
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (rom_we) rom[rom_a[fbc_pkg::ROM_AW-1:0]] <= val_r;
    if (32'(rom_a) < fbc_pkg::ROM_DEPTH) rom_q <= rom[rom_a[fbc_pkg::ROM_AW-1:0]];
    else rom_q <= 8'hff;
  end

  logic dwe, swe;
  logic [fbc_pkg::DRAM_AW-1:0] dwa;
  logic [fbc_pkg::SRAM_AW-1:0] swa;
  logic [3:0] dwd;
  always_comb begin
    if (st_r == fbc_pkg::ST_CLEAR) begin
      dwe = 1'b1; swe = 1'b1; dwd = 4'd0;
      dwa = clr_r[fbc_pkg::DRAM_AW-1:0];
      swa = clr_r[fbc_pkg::SRAM_AW-1:0];
    end else begin
      dwe = st_r == fbc_pkg::ST_DEC1 && hi == 4'he && lo == 4'h0 && bank_ok;
      swe = st_r == fbc_pkg::ST_DEC1 && hi == 4'he && lo[3:2] == 2'b01 && bank_ok;
      dwd = acc_r; dwa = da; swa = sa;
    end
  end
  always_ff @(posedge clk) begin
    if (dwe) dram[dwa] <= dwd;
    if (swe) sram[swa] <= dwd;
    dram_q <= dram[da];
    sram_q <= sram[sa];
  end

  logic [11:0] pc_inc;
  assign pc_inc = stk_r[0] + 12'd1;
  logic jcn;
  assign jcn = (((lo[2] && acc_r == 4'd0) || (lo[1] && cy_r) || (lo[0] && !test_r)) ^ lo[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fbc_pkg::ST_CLEAR;
      clr_r <= '0;
      for (int i = 0; i < 16; i++) begin ports_r[i] <= 4'd0; idx_r[i] <= 4'd0; end
      for (int i = 0; i < 4; i++) stk_r[i] <= 12'd0;
      acc_r <= 4'd0; cy_r <= 1'b0; halt_r <= 1'b0; bank_r <= 3'd0;
      srch_r <= 4'd0; srcl_r <= 4'd0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        fbc_pkg::ST_CLEAR: clr_r <= clr_r + 1'b1;
        fbc_pkg::ST_IDLE:
          if (in_tvalid && in_tready) begin
            func_r <= in_tuser; addr_r <= in_tdata[11:0]; val_r <= in_tdata[19:12];
            test_r <= in_tdata[20];
            cyc_r <= 2'd0; pw_r <= 1'b0; pidx_r <= 5'd0; pval_r <= 4'd0;
          end
        fbc_pkg::ST_FETCH1: begin
          op_r <= rom_q;
          stk_r[0] <= pc_inc;
        end
        fbc_pkg::ST_DEC1: begin
          if (!two_byte && !fin_op && !ram_rd) ovalid_r <= 1'b1;
          cyc_r <= (two_byte || fin_op || ram_rd || (hi == 4'he && lo[3:2] == 2'b01) ||
                    (hi == 4'he && lo == 4'h0)) ? 2'd2 : 2'd1;
          unique case (hi)
            4'h0: if (lo != 4'h0) begin halt_r <= 1'b1; cyc_r <= 2'd0; end
            4'h2: if (lo[0]) begin srch_r <= idx_r[{lo[3:1], 1'b0}]; srcl_r <= idx_r[lo]; end
            4'h3: if (lo[0]) stk_r[0] <= {stk_r[0][11:8], idx_r[{lo[3:1], 1'b0}], idx_r[lo]};
            4'h6: idx_r[lo] <= asum[3:0];
            4'h8, 4'h9: begin acc_r <= asum[3:0]; cy_r <= asum[4]; end
            4'ha: acc_r <= idx_r[lo];
            4'hb: begin acc_r <= idx_r[lo]; idx_r[lo] <= acc_r; end
            4'hc: begin
              acc_r <= lo; stk_r[0] <= stk_r[1]; stk_r[1] <= stk_r[2]; stk_r[2] <= stk_r[3];
            end
            4'hd: acc_r <= lo;
            4'he: begin
              if (lo == 4'h1) begin
                pw_r <= 1'b1; pidx_r <= {bank_r, srch_r[3:2]}; pval_r <= acc_r;
              end
              if (lo == 4'h3) begin halt_r <= 1'b1; cyc_r <= 2'd0; end
              if (lo == 4'ha) acc_r <= ports_r[srch_r];
            end
            4'hf: begin
              unique case (lo)
                4'h0: begin acc_r <= 4'd0; cy_r <= 1'b0; end
                4'h1: cy_r <= 1'b0;
                4'h2: begin acc_r <= asum[3:0]; cy_r <= asum[4]; end
                4'h3: cy_r <= ~cy_r;
                4'h4: acc_r <= ~acc_r;
                4'h5: begin acc_r <= {acc_r[2:0], cy_r}; cy_r <= acc_r[3]; end
                4'h6: begin acc_r <= {cy_r, acc_r[3:1]}; cy_r <= acc_r[0]; end
                4'h7: begin acc_r <= {3'd0, cy_r}; cy_r <= 1'b0; end
                4'h8: begin acc_r <= asum[3:0]; cy_r <= asum[4]; end
                4'h9: begin acc_r <= cy_r ? 4'd10 : 4'd9; cy_r <= 1'b0; end
                4'ha: cy_r <= 1'b1;
                4'hb: begin
                  if (acc_r > 4'd9 || cy_r) begin
                    acc_r <= acc_r + 4'd6;
                    if (acc_r > 4'd9) cy_r <= 1'b1;
                  end
                end
                4'hc: acc_r <= fbc_pkg::kbp(acc_r);
                4'hd: bank_r <= fbc_pkg::bank_code(acc_r[2:0]);
                default: begin halt_r <= 1'b1; cyc_r <= 2'd0; end
              endcase
            end
            default: ;
          endcase
        end
        fbc_pkg::ST_FETCH2: begin
          b2_r <= rom_q;
          stk_r[0] <= pc_inc;
        end
        fbc_pkg::ST_DEC2: begin
          ovalid_r <= 1'b1;
          unique case (hi)
            4'h1: if (jcn) stk_r[0] <= {stk_r[0][11:8], b2_r};
            4'h2: begin idx_r[{lo[3:1], 1'b0}] <= b2_r[7:4]; idx_r[{lo[3:1], 1'b1}] <= b2_r[3:0]; end
            4'h4: stk_r[0] <= {lo, b2_r};
            4'h5: begin
              stk_r[3] <= stk_r[2]; stk_r[2] <= stk_r[1]; stk_r[1] <= stk_r[0];
              stk_r[0] <= {lo, b2_r};
            end
            4'h7: begin
              idx_r[lo] <= asum[3:0];
              if (asum[3:0] != 4'd0) stk_r[0] <= {stk_r[0][11:8], b2_r};
            end
            default: ;
          endcase
        end
        fbc_pkg::ST_FINWR: begin
          ovalid_r <= 1'b1;
          idx_r[{lo[3:1], 1'b0}] <= rom_q[7:4]; idx_r[{lo[3:1], 1'b1}] <= rom_q[3:0];
        end
        fbc_pkg::ST_RAMEX: begin
          ovalid_r <= 1'b1;
          if (lo == 4'h9) acc_r <= bank_ok ? dram_q : 4'd0;
          else if (lo >= 4'hc) acc_r <= bank_ok ? sram_q : 4'd0;
          else begin acc_r <= asum[3:0]; cy_r <= asum[4]; end
        end
        fbc_pkg::ST_DONE: begin
          ovalid_r <= 1'b1;
          if (func_r == fbc_pkg::FUNC_PORT && addr_r < 12'd16) ports_r[addr_r[3:0]] <= val_r[3:0];
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {2'b00, pval_r, pidx_r, pw_r, cyc_r, halt_r, cy_r, acc_r, stk_r[0]};

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("request taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  a_noready_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == fbc_pkg::ST_CLEAR) |-> !in_tready) else $error("ready during clear");
endmodule

// ----- bench/fbc_step_checker.sv -----
// fbc_step_checker: instruction-level predictor and scoreboard for the four-bit core step block
// depends on fbc_pkg (sizes, request codes); fbc_tb_pkg below holds the opcode names for the bench
`timescale 1ns / 1ps
package fbc_tb_pkg;
  typedef enum logic [3:0] {
    GRP_NOP, GRP_JCN, GRP_FIM_SRC, GRP_FIN_JIN, GRP_JUN, GRP_JMS, GRP_INC, GRP_ISZ,
    GRP_ADD, GRP_SUB, GRP_LD, GRP_XCH, GRP_BBL, GRP_LDM, GRP_IO, GRP_ACC
  } op_group_t;

  typedef enum logic [3:0] {
    IO_WRM, IO_WMP, IO_WRR, IO_WPM, IO_WR0, IO_WR1, IO_WR2, IO_WR3,
    IO_SBM, IO_RDM, IO_RDR, IO_ADM, IO_RD0, IO_RD1, IO_RD2, IO_RD3
  } io_op_t;

  typedef enum logic [3:0] {
    AC_CLB, AC_CLC, AC_IAC, AC_CMC, AC_CMA, AC_RAL, AC_RAR, AC_TCC,
    AC_DAC, AC_TCS, AC_STC, AC_DAA, AC_KBP, AC_DCL, AC_BAD0, AC_BAD1
  } acc_op_t;

  localparam logic [1:0] FUNC_NOP = 2'd3;
endpackage

module fbc_step_checker
  import fbc_pkg::*;
  import fbc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          errors,
  output int          outstanding
);
  typedef struct {
    logic [11:0] pc;
    logic [3:0]  acc;
    logic        carry;
    logic        halted;
    logic [1:0]  cycles;
    logic        port_wr;
    logic [4:0]  port_idx;
    logic [3:0]  port_val;
  } core_status_t;

  core_status_t expected_status[$];

  logic [7:0]  rom [ROM_DEPTH];
  logic [3:0]  dram [DRAM_DEPTH];
  logic [3:0]  sram [SRAM_DEPTH];
  logic [3:0]  rom_ports [16];
  logic [3:0]  regs [16];
  logic [11:0] stk [4];
  logic [3:0]  acc, src_hi, src_lo;
  logic        cy, halt;
  logic [2:0]  bank;
  logic        wmp_seen;
  logic [4:0]  wmp_idx;
  logic [3:0]  wmp_val;

  assign outstanding = expected_status.size();

  function automatic logic [7:0] next_byte();
    next_byte = rom[stk[0]];
    stk[0] = stk[0] + 12'd1;
  endfunction

  function automatic void add_nibble(input logic [3:0] op);
    logic [4:0] s;
    s = acc + op + cy;
    cy = s[4];
    acc = s[3:0];
  endfunction

  function automatic void load_pair(input logic [3:0] lo, input logic [7:0] b);
    regs[{lo[3:1], 1'b0}] = b[7:4];
    regs[{lo[3:1], 1'b1}] = b[3:0];
  endfunction

  function automatic logic [10:0] dram_idx();
    return {bank, src_hi, src_lo};
  endfunction

  function automatic logic [8:0] sram_idx(input logic [1:0] n);
    return {bank, src_hi, n};
  endfunction

  function automatic int run_io(input logic [3:0] lo);
    case (io_op_t'(lo))
      IO_WRM: begin dram[dram_idx()] = acc; return 2; end
      IO_WMP: begin
        wmp_seen = 1'b1;
        wmp_idx = {bank, src_hi[3:2]};
        wmp_val = acc;
        return 1;
      end
      IO_WRR: return 1;
      IO_WPM: begin halt = 1'b1; return 0; end
      IO_WR0, IO_WR1, IO_WR2, IO_WR3: begin sram[sram_idx(lo[1:0])] = acc; return 2; end
      IO_SBM: begin add_nibble(~dram[dram_idx()]); return 2; end
      IO_RDM: begin acc = dram[dram_idx()]; return 2; end
      IO_RDR: begin acc = rom_ports[src_hi]; return 1; end
      IO_ADM: begin add_nibble(dram[dram_idx()]); return 2; end
      default: begin acc = sram[sram_idx(lo[1:0])]; return 2; end
    endcase
  endfunction

  function automatic int run_acc(input logic [3:0] lo);
    logic [4:0] t;
    case (acc_op_t'(lo))
      AC_CLB: begin acc = 4'd0; cy = 1'b0; end
      AC_CLC: cy = 1'b0;
      AC_IAC: begin cy = (acc == 4'd15); acc = acc + 4'd1; end
      AC_CMC: cy = ~cy;
      AC_CMA: acc = ~acc;
      AC_RAL: {cy, acc} = {acc, cy};
      AC_RAR: {acc, cy} = {cy, acc};
      AC_TCC: begin acc = {3'd0, cy}; cy = 1'b0; end
      AC_DAC: begin cy = (acc != 4'd0); acc = acc - 4'd1; end
      AC_TCS: begin acc = cy ? 4'd10 : 4'd9; cy = 1'b0; end
      AC_STC: cy = 1'b1;
      AC_DAA: begin
        t = {1'b0, acc};
        if (t > 5'd9 || cy) t = t + 5'd6;
        if (t > 5'd15) cy = 1'b1;
        acc = t[3:0];
      end
      AC_KBP: begin
        // zero or a one-hot keyboard code to key number, anything else is an error code
        if (acc == 4'd4) acc = 4'd3;
        else if (acc == 4'd8) acc = 4'd4;
        else if (acc > 4'd2) acc = 4'd15;
      end
      AC_DCL: begin
        // codes 3 and 4 select banks 4 and 3
        if (acc[2:0] == 3'd3) bank = 3'd4;
        else if (acc[2:0] == 3'd4) bank = 3'd3;
        else bank = acc[2:0];
      end
      default: begin halt = 1'b1; return 0; end
    endcase
    return 1;
  endfunction

  function automatic int run_instr(input logic test);
    logic [7:0] opc, b;
    logic [3:0] lo;
    logic       jump;
    opc = next_byte();
    lo = opc[3:0];
    case (op_group_t'(opc[7:4]))
      GRP_NOP: begin
        if (lo == 4'd0) return 1;
        halt = 1'b1;
        return 0;
      end
      GRP_JCN: begin
        b = next_byte();
        jump = (lo[2] && acc == 4'd0) || (lo[1] && cy) || (lo[0] && !test);
        if (lo[3]) jump = !jump;
        if (jump) stk[0] = {stk[0][11:8], b};
        return 2;
      end
      GRP_FIM_SRC: begin
        if (lo[0]) begin
          src_hi = regs[{lo[3:1], 1'b0}];
          src_lo = regs[{lo[3:1], 1'b1}];
          return 1;
        end
        load_pair(lo, next_byte());
        return 2;
      end
      GRP_FIN_JIN: begin
        if (lo[0]) begin
          stk[0] = {stk[0][11:8], regs[{lo[3:1], 1'b0}], regs[{lo[3:1], 1'b1}]};
          return 1;
        end
        load_pair(lo, rom[{stk[0][11:8], regs[0], regs[1]}]);
        return 2;
      end
      GRP_JUN: begin b = next_byte(); stk[0] = {lo, b}; return 2; end
      GRP_JMS: begin
        b = next_byte();
        stk[3] = stk[2];
        stk[2] = stk[1];
        stk[1] = stk[0];
        stk[0] = {lo, b};
        return 2;
      end
      GRP_INC: begin regs[lo] = regs[lo] + 4'd1; return 1; end
      GRP_ISZ: begin
        b = next_byte();
        regs[lo] = regs[lo] + 4'd1;
        if (regs[lo] != 4'd0) stk[0] = {stk[0][11:8], b};
        return 2;
      end
      GRP_ADD: begin add_nibble(regs[lo]); return 1; end
      GRP_SUB: begin add_nibble(~regs[lo]); return 1; end
      GRP_LD: begin acc = regs[lo]; return 1; end
      GRP_XCH: begin b[3:0] = acc; acc = regs[lo]; regs[lo] = b[3:0]; return 1; end
      GRP_BBL: begin
        acc = lo;
        stk[0] = stk[1];
        stk[1] = stk[2];
        stk[2] = stk[3];
        return 1;
      end
      GRP_LDM: begin acc = lo; return 1; end
      GRP_IO: return run_io(lo);
      default: return run_acc(lo);
    endcase
  endfunction

  function automatic core_status_t apply_request(input logic [1:0] func,
                                                 input logic [11:0] addr,
                                                 input logic [7:0] val,
                                                 input logic test);
    core_status_t r;
    int cyc;
    cyc = 0;
    wmp_seen = 1'b0;
    wmp_idx = '0;
    wmp_val = '0;
    if (func == FUNC_EXEC) begin
      if (!halt) cyc = run_instr(test);
    end else if (func == FUNC_LOAD) begin
      rom[addr] = val;
    end else if (func == FUNC_PORT) begin
      if (addr < 12'd16) rom_ports[addr[3:0]] = val[3:0];
    end
    r.pc = stk[0];
    r.acc = acc;
    r.carry = cy;
    r.halted = halt;
    r.cycles = cyc[1:0];
    r.port_wr = wmp_seen;
    r.port_idx = wmp_idx;
    r.port_val = wmp_val;
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    core_status_t e;
    if (!rst_n) begin
      foreach (dram[i]) dram[i] = '0;
      foreach (sram[i]) sram[i] = '0;
      foreach (rom_ports[i]) rom_ports[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      acc = '0;
      cy = 1'b0;
      bank = '0;
      src_hi = '0;
      src_lo = '0;
      halt = 1'b0;
      expected_status.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_status.push_back(apply_request(in_tuser, in_tdata[11:0], in_tdata[19:12],
                                                in_tdata[20]));
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request pending, got %h", $time, out_tdata);
        end else begin
          e = expected_status.pop_front();
          check_field("pc_out", e.pc, out_tdata[11:0]);
          check_field("acc_out", e.acc, out_tdata[15:12]);
          check_field("carry_out", e.carry, out_tdata[16]);
          check_field("halted", e.halted, out_tdata[17]);
          check_field("cycles_used", e.cycles, out_tdata[19:18]);
          check_field("port_write", e.port_wr, out_tdata[20]);
          check_field("port_index", e.port_idx, out_tdata[25:21]);
          check_field("port_value", e.port_val, out_tdata[29:26]);
        end
      end
    end
  end
endmodule

// ----- bench/four_bit_cpu_instruction_step_tb.sv -----
// four_bit_cpu_instruction_step_tb: stimulus and verdict for the four-bit core step block
// depends on fbc_pkg, fbc_tb_pkg and fbc_step_checker (bench/fbc_step_checker.sv)
`timescale 1ns / 1ps
module four_bit_cpu_instruction_step_tb;
  import fbc_pkg::*;
  import fbc_tb_pkg::*;

  localparam int STALL_LIMIT = 12000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // address[11:0], value[19:12], test_pin[20]
  logic [1:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // pc_out, acc_out, carry_out, halted, cycles_used, port fields
  int          errors;
  int          outstanding;
  int          tx_idle, rx_idle;
  int          quiet_cycles;
  int          n_exec, n_load, n_port;
  logic [11:0] last_pc;

  four_bit_cpu_instruction_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  fbc_step_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) if (out_tvalid && out_tready) last_pc <= out_tdata[11:0];

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t ns: no progress on either channel", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit stops_core(input logic [7:0] b);
    return (b[7:4] == GRP_NOP && b[3:0] != 4'd0) || b == {GRP_IO, IO_WPM} ||
           b == {GRP_ACC, AC_BAD0} || b == {GRP_ACC, AC_BAD1};
  endfunction

  function automatic logic [7:0] runnable_byte();
    logic [7:0] b;
    do b = $urandom; while (stops_core(b));
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send(input logic [1:0] func, input logic [11:0] addr, input logic [7:0] val,
                      input logic test);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {3'd0, test, val, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (func == FUNC_EXEC) n_exec++;
    else if (func == FUNC_LOAD) n_load++;
    else if (func == FUNC_PORT) n_port++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 74)
      send(FUNC_EXEC, $urandom, $urandom, $urandom);
    else if (pick < 86)
      send(FUNC_LOAD, $urandom, runnable_byte(), $urandom);
    else if (pick < 96)
      send(FUNC_PORT, $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(31)),
           $urandom, $urandom);
    else
      send(FUNC_NOP, $urandom, $urandom, $urandom);
  endtask

  logic [7:0] demo_prog [] = '{
    {GRP_FIM_SRC, 4'h0}, 8'hFF,   // pair 0 = ff
    {GRP_FIM_SRC, 4'h2}, 8'h3C,   // pair 1 = 3c
    {GRP_FIM_SRC, 4'h1},          // src from pair 0
    {GRP_LDM, 4'hF},
    {GRP_IO, IO_WRM}, {GRP_IO, IO_WMP}, {GRP_IO, IO_WR0}, {GRP_IO, IO_WR3},
    {GRP_IO, IO_ADM}, {GRP_IO, IO_SBM}, {GRP_IO, IO_RDM}, {GRP_IO, IO_RD3},
    {GRP_ACC, AC_DCL}, {GRP_IO, IO_WMP}, {GRP_IO, IO_RDR}, {GRP_IO, IO_WRR},
    {GRP_ACC, AC_RAL}, {GRP_ACC, AC_RAR}, {GRP_ACC, AC_DAA}, {GRP_ACC, AC_KBP},
    {GRP_ACC, AC_STC}, {GRP_ACC, AC_TCS}, {GRP_ACC, AC_IAC}, {GRP_ACC, AC_DAC},
    {GRP_ACC, AC_CMA}, {GRP_ACC, AC_CMC}, {GRP_ACC, AC_TCC}, {GRP_ACC, AC_CLC},
    {GRP_ACC, AC_CLB}, {GRP_NOP, 4'h0},
    {GRP_ADD, 4'h2}, {GRP_SUB, 4'h3}, {GRP_LD, 4'h1}, {GRP_XCH, 4'h4}, {GRP_INC, 4'hF},
    {GRP_ISZ, 4'h5}, 8'h2A,
    {GRP_JCN, 4'h4}, 8'h2C,       // acc zero so this jumps
    8'h00, 8'h00,
    {GRP_JMS, 4'h0}, 8'h40,
    {GRP_JCN, 4'h9}, 8'h3B,       // inverted test condition
    {GRP_FIN_JIN, 4'h2},          // fetch indirect through pair 0
    {GRP_JUN, 4'h0}, 8'h50
  };

  initial begin
    int i;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_NOP;
    out_tready = 1'b0;
    rst_n = 1'b0;
    quiet_cycles = 0;
    n_exec = 0; n_load = 0; n_port = 0;
    last_pc = '0;
    tx_idle = 0;
    rx_idle = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every rom byte gets a runnable opcode, so no fetch ever lands on an unloaded byte
    for (i = 0; i < ROM_DEPTH; i++) send(FUNC_LOAD, i, runnable_byte(), $urandom);
    foreach (demo_prog[k]) send(FUNC_LOAD, k, demo_prog[k], 1'b0);
    send(FUNC_LOAD, 12'h040, {GRP_BBL, 4'h7}, 1'b0);
    send(FUNC_PORT, 12'd15, 8'hA9, 1'b0);
    send(FUNC_PORT, 12'd16, 8'h55, 1'b0);
    for (i = 0; i < 36; i++) send(FUNC_EXEC, 12'hFFF, 8'hFF, i[0]);

    tx_idle = 33; rx_idle = 58;
    for (i = 0; i < 220; i++) random_request();
    tx_idle = 58; rx_idle = 33;
    for (i = 0; i < 220; i++) random_request();
    tx_idle = 0; rx_idle = 0;
    for (i = 0; i < 220; i++) random_request();

    // program counter wrap: jump to the last rom byte and step past it
    settle();
    send(FUNC_LOAD, last_pc, {GRP_JUN, 4'hF}, 1'b0);
    send(FUNC_LOAD, last_pc + 12'd1, 8'hFF, 1'b0);
    send(FUNC_LOAD, 12'hFFF, {GRP_ACC, AC_IAC}, 1'b0);
    repeat (3) send(FUNC_EXEC, '0, '0, 1'b1);

    // an undefined opcode stops the core for good
    settle();
    send(FUNC_LOAD, last_pc, {GRP_NOP, 4'(1 + $urandom_range(14))}, 1'b0);
    repeat (3) send(FUNC_EXEC, '0, '0, 1'b0);
    send(FUNC_NOP, '0, '0, 1'b0);
    send(FUNC_PORT, 12'd3, 8'h07, 1'b0);

    in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d executes, %0d rom loads and %0d port writes", n_exec, n_load, n_port);
    $display("across three handshake idling mixes, a pc wrap and a final halt");
    if (errors == 0 && outstanding == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
